>>> src/bmhq_pkg.sv
`default_nettype none
package bmhq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int FUNC_W       = 3;
    localparam int COUNT_OUT_W  = 11;
    localparam int STATUS_W     = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage
`default_nettype wire

>>> src/binary_min_heap_queue.sv
// Min-heap priority queue of signed 32-bit keys held in a single RAM with one
// write and one registered read port. Each item (push, pop, clear, load,
// build) returns one result: the root key (zero when empty), an empty flag,
// the entry count and a status. Push climbs the new key from the last slot
// towards the root, pop moves the last key to the root and sifts it down,
// and build sifts each parent down in turn. The single RAM read port
// delivers one key per cycle. The fill count bounds every read, so no
// clearing pass is needed after reset. A finished result waits in the
// output register while the next item is accepted.
`default_nettype none
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [bmhq_pkg::FUNC_W-1:0]        s_func,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]  s_key_value,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [bmhq_pkg::KEY_W-1:0]       m_min_key,
    output logic                                    m_is_empty,
    output logic [bmhq_pkg::COUNT_OUT_W-1:0]        m_entry_count,
    output logic [bmhq_pkg::STATUS_W-1:0]           m_status
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = AW + 1;
    localparam int KW    = bmhq_pkg::KEY_W;
    localparam int EXT_W = CW + bmhq_pkg::COUNT_OUT_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SU_RD   = 4'd1;
    localparam logic [3:0] ST_SU_CMP  = 4'd2;
    localparam logic [3:0] ST_RD_LAST = 4'd3;
    localparam logic [3:0] ST_SD_L    = 4'd4;
    localparam logic [3:0] ST_SD_R    = 4'd5;
    localparam logic [3:0] ST_SD_CMP  = 4'd6;
    localparam logic [3:0] ST_BLD_RD  = 4'd7;
    localparam logic [3:0] ST_BLD_V   = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]                      state_reg, state_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [AW-1:0]                   bi_reg, bi_next;
    logic signed [KW-1:0]            v_reg, v_next;
    logic signed [KW-1:0]            lkey_reg, lkey_next;
    logic signed [KW-1:0]            root_reg;
    logic [bmhq_pkg::FUNC_W-1:0]     op_reg, op_next;
    logic [bmhq_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            out_valid_reg;
    logic signed [KW-1:0]            out_key_reg;
    logic                            out_empty_reg;
    logic [bmhq_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic [bmhq_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_load;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic signed [KW-1:0]            ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [KW-1:0]                   ram_rdata;
    logic signed [KW-1:0]            rd_key;

    logic [IW-1:0]                   l_idx;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   n_ext;
    logic                            l_ok;
    logic                            r_ok;
    logic [AW-1:0]                   up_idx;
    logic [CW-1:0]                   n_dec;
    logic [EXT_W-1:0]                cnt_ext;
    logic                            full;

    bmhq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key = $signed(ram_rdata);
    assign l_idx  = {pos_reg, 1'b1};
    assign r_idx  = IW'({pos_reg, 1'b1}) + IW'(1);
    assign n_ext  = IW'(n_reg);
    assign l_ok   = l_idx < n_ext;
    assign r_ok   = r_idx < n_ext;
    assign up_idx = (pos_reg - AW'(1)) >> 1;
    assign n_dec  = n_reg - CW'(1);
    assign full   = n_reg == CW'(CAPACITY);

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        bi_next     = bi_reg;
        v_next      = v_reg;
        lkey_next   = lkey_reg;
        op_next     = op_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = v_reg;
        ram_raddr   = pos_reg;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_func;
                    status_next = bmhq_pkg::STATUS_OK;
                    state_next  = ST_DONE;
                    case (s_func)
                        bmhq_pkg::FUNC_PUSH: begin
                            if (full) begin
                                status_next = bmhq_pkg::STATUS_FULL;
                            end else begin
                                pos_next   = n_reg[AW-1:0];
                                v_next     = s_key_value;
                                n_next     = n_reg + CW'(1);
                                state_next = ST_SU_RD;
                            end
                        end
                        bmhq_pkg::FUNC_LOAD: begin
                            if (full) begin
                                status_next = bmhq_pkg::STATUS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = n_reg[AW-1:0];
                                ram_wdata = s_key_value;
                                n_next    = n_reg + CW'(1);
                            end
                        end
                        bmhq_pkg::FUNC_POP: begin
                            if (n_reg == '0) begin
                                status_next = bmhq_pkg::STATUS_EMPTY;
                            end else begin
                                ram_raddr  = n_dec[AW-1:0];
                                n_next     = n_dec;
                                state_next = ST_RD_LAST;
                            end
                        end
                        bmhq_pkg::FUNC_CLEAR: begin
                            n_next = '0;
                        end
                        bmhq_pkg::FUNC_BUILD: begin
                            if (n_reg >= CW'(2)) begin
                                bi_next    = AW'(n_reg >> 1);
                                state_next = ST_BLD_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // climb: hole at pos, moving key held in v_reg
            ST_SU_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    ram_raddr  = up_idx;
                    state_next = ST_SU_CMP;
                end
            end
            ST_SU_CMP: begin
                ram_we = 1'b1;
                if (v_reg < rd_key) begin
                    ram_wdata  = rd_key;
                    pos_next   = up_idx;
                    state_next = ST_SU_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_RD_LAST: begin
                v_next     = rd_key;
                pos_next   = '0;
                state_next = ST_SD_L;
            end

            // descend: read left, then right, then pick the smaller child
            ST_SD_L: begin
                if (l_ok) begin
                    ram_raddr  = l_idx[AW-1:0];
                    state_next = ST_SD_R;
                end else begin
                    ram_we     = 1'b1;
                    state_next = (op_reg == bmhq_pkg::FUNC_BUILD) ? ST_BLD_RD : ST_DONE;
                end
            end
            ST_SD_R: begin
                lkey_next  = rd_key;
                ram_raddr  = r_ok ? r_idx[AW-1:0] : l_idx[AW-1:0];
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP: begin
                ram_we = 1'b1;
                if (r_ok && (rd_key < lkey_reg) && (rd_key < v_reg)) begin
                    ram_wdata  = rd_key;
                    pos_next   = r_idx[AW-1:0];
                    state_next = ST_SD_L;
                end else if (lkey_reg < v_reg) begin
                    ram_wdata  = lkey_reg;
                    pos_next   = l_idx[AW-1:0];
                    state_next = ST_SD_L;
                end else begin
                    state_next = (op_reg == bmhq_pkg::FUNC_BUILD) ? ST_BLD_RD : ST_DONE;
                end
            end

            ST_BLD_RD: begin
                if (bi_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    ram_raddr  = bi_reg - AW'(1);
                    pos_next   = bi_reg - AW'(1);
                    bi_next    = bi_reg - AW'(1);
                    state_next = ST_BLD_V;
                end
            end
            ST_BLD_V: begin
                v_next     = rd_key;
                state_next = ST_SD_L;
            end

            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt_ext = EXT_W'(n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_next_hold: begin
            pos_reg    <= pos_next;
            bi_reg     <= bi_next;
            v_reg      <= v_next;
            lkey_reg   <= lkey_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
        // mirror the root so the result needs no extra read
        if (ram_we && ram_waddr == '0) begin
            root_reg <= ram_wdata;
        end
        if (out_load) begin
            out_key_reg    <= (n_reg != '0) ? root_reg : '0;
            out_empty_reg  <= n_reg == '0;
            out_count_reg  <= cnt_ext[bmhq_pkg::COUNT_OUT_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = out_valid_reg;
    assign m_min_key     = out_key_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_entry_count = out_count_reg;
    assign m_status      = out_status_reg;

endmodule
`default_nettype wire

>>> src/bmhq_ram.sv
`default_nettype none
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS      = 40;
    localparam int HOLD_AT           = 10;
    localparam int HOLD_ITEMS        = 10;
    localparam int PAUSE_AT          = 25;
    localparam int QUIET_ITEMS       = 150;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS       = 10;

    localparam logic [bmhq_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [bmhq_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [bmhq_pkg::FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    typedef logic signed [bmhq_pkg::KEY_W-1:0] heap_key_t;

    localparam heap_key_t KEY_MIN = {1'b1, {(bmhq_pkg::KEY_W-1){1'b0}}};
    localparam heap_key_t KEY_MAX = {1'b0, {(bmhq_pkg::KEY_W-1){1'b1}}};

    typedef struct packed {
        logic signed [bmhq_pkg::KEY_W-1:0]  min_key;
        logic                               is_empty;
        logic [bmhq_pkg::COUNT_OUT_W-1:0]   entry_count;
        logic [bmhq_pkg::STATUS_W-1:0]      status;
    } heap_result_t;

    class heap_scoreboard;
        heap_key_t      heap_keys [bmhq_pkg::CAPACITY_DEF];
        int unsigned    heap_fill;
        heap_result_t   pending_results [$];
        int             error_count;

        function new();
            heap_fill   = 0;
            error_count = 0;
        endfunction

        function void swap_keys(int unsigned a, int unsigned b);
            heap_key_t t;
            t            = heap_keys[a];
            heap_keys[a] = heap_keys[b];
            heap_keys[b] = t;
        endfunction

        function void sift_down(int unsigned pos);
            int unsigned lchild, rchild, least;
            forever begin
                lchild = 2 * pos + 1;
                rchild = 2 * pos + 2;
                least  = pos;
                // swap only on strictly smaller; left child wins a tie
                if (lchild < heap_fill && heap_keys[lchild] < heap_keys[least]) least = lchild;
                if (rchild < heap_fill && heap_keys[rchild] < heap_keys[least]) least = rchild;
                if (least == pos) return;
                swap_keys(pos, least);
                pos = least;
            end
        endfunction

        function void sift_up(int unsigned pos);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(heap_keys[pos] < heap_keys[parent])) return;
                swap_keys(pos, parent);
                pos = parent;
            end
        endfunction

        // Apply one accepted item to the heap copy and queue its result.
        function void note_item(logic [bmhq_pkg::FUNC_W-1:0] op, heap_key_t key);
            heap_result_t                  res;
            logic [bmhq_pkg::STATUS_W-1:0] st;
            int unsigned                   i;
            st = bmhq_pkg::STATUS_OK;
            case (op)
                bmhq_pkg::FUNC_PUSH, bmhq_pkg::FUNC_LOAD: begin
                    if (heap_fill >= bmhq_pkg::CAPACITY_DEF) begin
                        st = bmhq_pkg::STATUS_FULL;
                    end else begin
                        heap_keys[heap_fill] = key;
                        heap_fill++;
                        if (op == bmhq_pkg::FUNC_PUSH) sift_up(heap_fill - 1);
                    end
                end
                bmhq_pkg::FUNC_POP: begin
                    if (heap_fill == 0) begin
                        st = bmhq_pkg::STATUS_EMPTY;
                    end else begin
                        heap_keys[0] = heap_keys[heap_fill - 1];
                        heap_fill--;
                        sift_down(0);
                    end
                end
                bmhq_pkg::FUNC_CLEAR: heap_fill = 0;
                bmhq_pkg::FUNC_BUILD: begin
                    if (heap_fill >= 2) begin
                        for (i = heap_fill / 2; i > 0; i--) sift_down(i - 1);
                    end
                end
                default: ;
            endcase
            res.min_key     = (heap_fill > 0) ? heap_keys[0] : '0;
            res.is_empty    = (heap_fill == 0);
            res.entry_count = heap_fill[bmhq_pkg::COUNT_OUT_W-1:0];
            res.status      = st;
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(heap_key_t min_key, logic is_empty,
                                   logic [bmhq_pkg::COUNT_OUT_W-1:0] entry_count,
                                   logic [bmhq_pkg::STATUS_W-1:0] status);
            heap_result_t want;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: min_key %0d is_empty %0d count %0d status %0d",
                             min_key, is_empty, entry_count, status);
                return;
            end
            want = pending_results.pop_front();
            if (min_key !== want.min_key || is_empty !== want.is_empty ||
                entry_count !== want.entry_count || status !== want.status) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("result mismatch at %0t:", $realtime);
                    $display("  min_key     exp %0d got %0d", $signed(want.min_key), min_key);
                    $display("  is_empty    exp %0d got %0d", want.is_empty, is_empty);
                    $display("  entry_count exp %0d got %0d", want.entry_count, entry_count);
                    $display("  status      exp %0d got %0d", want.status, status);
                end
            end
        endfunction
    endclass

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [bmhq_pkg::FUNC_W-1:0]         s_func;
    logic signed [bmhq_pkg::KEY_W-1:0]   s_key_value;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [bmhq_pkg::KEY_W-1:0]   m_min_key;
    logic                                m_is_empty;
    logic [bmhq_pkg::COUNT_OUT_W-1:0]    m_entry_count;
    logic [bmhq_pkg::STATUS_W-1:0]       m_status;

    bit idling_on;
    bit long_hold_req;

    heap_scoreboard sb = new();

    binary_min_heap_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key_value   (s_key_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_min_key     (m_min_key),
        .m_is_empty    (m_is_empty),
        .m_entry_count (m_entry_count),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("[binary_min_heap_queue] ERROR");
        $finish;
    end

    // Check the result first: an item accepted on the same edge cannot own it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_min_key, m_is_empty, m_entry_count, m_status);
            if (s_valid && s_ready)
                sb.note_item(s_func, s_key_value);
        end
    end

    // Result side: ready in bursts, stalls in bursts, one long hold on request.
    initial begin
        bit hold_taken;
        int burst;
        hold_taken = 1'b0;
        burst      = 0;
        m_ready    = 1'b0;
        @(negedge aclk);
        forever begin
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                burst = $urandom_range(1, 30);
                // cut the burst short once the long hold is requested
                while (burst > 0 && !(long_hold_req && !hold_taken)) begin
                    @(negedge aclk);
                    burst--;
                end
            end
        end
    end

    function automatic heap_key_t rand_key();
        heap_key_t k;
        case ($urandom_range(0, 5))
            0, 1: k = $urandom;
            2, 3: k = $signed($urandom_range(0, 16)) - 8;
            4: begin
                case ($urandom_range(0, 3))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = '0;
                    default: k = '1;
                endcase
            end
            default: k = $urandom_range(0, 1000);
        endcase
        return k;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input logic [bmhq_pkg::FUNC_W-1:0] op, input heap_key_t key);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= op;
        s_key_value <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic run_sequence(inout int n);
        int len;
        int kind;
        logic [bmhq_pkg::FUNC_W-1:0] op;
        len  = $urandom_range(1, 12);
        // keep the heap small so builds stay short
        kind = (sb.heap_fill > 120) ? 3 : $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                repeat (len) begin
                    send_item(bmhq_pkg::FUNC_PUSH, rand_key());
                    n++;
                end
            end
            3, 4, 5: begin
                repeat (len) begin
                    send_item(bmhq_pkg::FUNC_POP, rand_key());
                    n++;
                end
            end
            6: begin
                repeat (len) begin
                    send_item(bmhq_pkg::FUNC_LOAD, rand_key());
                    n++;
                end
                send_item(bmhq_pkg::FUNC_BUILD, rand_key());
                n++;
            end
            7: begin
                op = bmhq_pkg::FUNC_W'($urandom_range(0, 7));
                send_item(op, rand_key());
                n++;
            end
            8: begin
                repeat (len) begin
                    op = ($urandom_range(0, 1) == 0) ? bmhq_pkg::FUNC_PUSH : bmhq_pkg::FUNC_POP;
                    send_item(op, rand_key());
                    n++;
                end
            end
            default: begin
                op = (sb.heap_fill > 40 || $urandom_range(0, 3) == 0) ?
                     bmhq_pkg::FUNC_CLEAR : bmhq_pkg::FUNC_BUILD;
                send_item(op, rand_key());
                n++;
            end
        endcase
    endtask

    // Load up to capacity, then hit the overflow path and sift the full depth.
    // Idling stops for the last stretch of the run.
    task automatic fill_to_capacity();
        int loads;
        int i;
        loads = bmhq_pkg::CAPACITY_DEF - int'(sb.heap_fill);
        for (i = 0; i < loads; i++) begin
            if (i >= loads - QUIET_ITEMS) idling_on = 1'b0;
            send_item(bmhq_pkg::FUNC_LOAD, rand_key());
        end
        idling_on = 1'b0;
        send_item(bmhq_pkg::FUNC_PUSH, KEY_MIN);
        send_item(bmhq_pkg::FUNC_LOAD, KEY_MAX);
        send_item(bmhq_pkg::FUNC_BUILD, rand_key());
        repeat (4) send_item(bmhq_pkg::FUNC_POP, rand_key());
        send_item(bmhq_pkg::FUNC_PUSH, KEY_MIN);
        repeat (3) send_item(bmhq_pkg::FUNC_PUSH, rand_key());
        send_item(bmhq_pkg::FUNC_PUSH, KEY_MAX);
        send_item(bmhq_pkg::FUNC_POP, rand_key());
        send_item(bmhq_pkg::FUNC_CLEAR, rand_key());
    endtask

    initial begin
        int random_sent;
        bit hold_done;
        bit pause_done;

        random_sent      = 0;
        hold_done        = 1'b0;
        pause_done       = 1'b0;
        idling_on        = 1'b1;
        long_hold_req    = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_func           = bmhq_pkg::FUNC_PUSH;
        s_key_value      = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty heap corners and unused codes
        send_item(bmhq_pkg::FUNC_POP, KEY_MAX);
        send_item(bmhq_pkg::FUNC_BUILD, '0);
        send_item(FUNC_SPARE_A, '1);
        send_item(FUNC_SPARE_B, KEY_MIN);
        send_item(FUNC_SPARE_C, KEY_MAX);
        // extremes and equal keys
        send_item(bmhq_pkg::FUNC_PUSH, KEY_MAX);
        send_item(bmhq_pkg::FUNC_BUILD, '0);
        send_item(bmhq_pkg::FUNC_PUSH, KEY_MIN);
        send_item(bmhq_pkg::FUNC_PUSH, '0);
        send_item(bmhq_pkg::FUNC_PUSH, '1);
        send_item(bmhq_pkg::FUNC_PUSH, '1);
        repeat (5) send_item(bmhq_pkg::FUNC_POP, '0);
        send_item(bmhq_pkg::FUNC_POP, '0);
        // equal smaller children: left one must move up
        send_item(bmhq_pkg::FUNC_LOAD, 32'sd5);
        send_item(bmhq_pkg::FUNC_LOAD, 32'sd1);
        send_item(bmhq_pkg::FUNC_LOAD, 32'sd1);
        send_item(bmhq_pkg::FUNC_BUILD, '0);
        send_item(bmhq_pkg::FUNC_POP, '0);
        send_item(bmhq_pkg::FUNC_POP, '0);
        send_item(bmhq_pkg::FUNC_LOAD, KEY_MIN);
        send_item(bmhq_pkg::FUNC_CLEAR, '0);

        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= HOLD_AT && !hold_done) begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
                // keep offering items while results back up
                repeat (HOLD_ITEMS) begin
                    send_item(($urandom_range(0, 1) == 0) ?
                              bmhq_pkg::FUNC_PUSH : bmhq_pkg::FUNC_POP, rand_key());
                    random_sent++;
                end
            end
            if (random_sent >= PAUSE_AT && !pause_done) begin
                pause_done = 1'b1;
                drain_results();
            end
            run_sequence(random_sent);
        end

        fill_to_capacity();

        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("[binary_min_heap_queue] OK");
        end else begin
            $display("[binary_min_heap_queue] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
